[rtl/core/chav_pkg.sv]
// shared types, constants and helpers of the cascaded history averager
package chav_pkg;

  localparam int CHANNELS     = 4;
  localparam int LEVELS       = 5;
  localparam int SECOND_DEPTH = 60;
  localparam int MINUTE_DEPTH = 60;
  localparam int HOUR_DEPTH   = 24;
  localparam int DAY_DEPTH    = 365;
  localparam int YEAR_DEPTH   = 10;

  localparam int MAX_A = (SECOND_DEPTH > MINUTE_DEPTH) ? SECOND_DEPTH : MINUTE_DEPTH;
  localparam int MAX_B = (HOUR_DEPTH > DAY_DEPTH) ? HOUR_DEPTH : DAY_DEPTH;
  localparam int MAX_C = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  localparam int MAX_DEPTH = (MAX_C > YEAR_DEPTH) ? MAX_C : YEAR_DEPTH;
  // position width, also holds the depth itself
  localparam int POS_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = 9;
  localparam int CMP_W = (POS_W > IDX_W) ? POS_W : IDX_W;

  localparam logic [2:0] LVL_SECOND = 3'd0;
  localparam logic [2:0] LVL_MINUTE = 3'd1;
  localparam logic [2:0] LVL_HOUR   = 3'd2;
  localparam logic [2:0] LVL_DAY    = 3'd3;
  localparam logic [2:0] LVL_YEAR   = 3'd4;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_ZERO   = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [1:0]  channel;
    logic [31:0] sample;
    logic [2:0]  level;
    logic [8:0]  entry_index;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  out_level;
    logic [1:0]  out_channel;
    logic        is_readback;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  channel;
    logic [31:0] sample;
    logic [2:0]  level;
    logic [8:0]  entry_index;
  } cmd_t;

  function automatic logic [POS_W-1:0] depth_of(input logic [2:0] lvl);
    logic [POS_W-1:0] d;
    unique case (lvl)
      LVL_SECOND: d = POS_W'(SECOND_DEPTH);
      LVL_MINUTE: d = POS_W'(MINUTE_DEPTH);
      LVL_HOUR:   d = POS_W'(HOUR_DEPTH);
      LVL_DAY:    d = POS_W'(DAY_DEPTH);
      LVL_YEAR:   d = POS_W'(YEAR_DEPTH);
      default:    d = '0;
    endcase
    return d;
  endfunction

  function automatic logic in_range(input logic [2:0] lvl, input logic [8:0] idx);
    return (lvl <= LVL_YEAR) && (CMP_W'(idx) < CMP_W'(depth_of(lvl)));
  endfunction

endpackage

[rtl/core/chav_front.sv]
// front end: config register, item acceptance and classification
module chav_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data,
  input  logic                item_valid,
  input  chav_pkg::item_t     item,
  output logic                item_stall,
  input  logic                q_full,
  output logic                push,
  output chav_pkg::cmd_t      cmd
);

  logic [2:0] active_channels;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= '0;
    end else if (cfg_we) begin
      active_channels <= cfg_data;
    end
  end

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;

  always_comb begin
    cmd.channel     = item.channel;
    cmd.sample      = item.sample;
    cmd.level       = item.level;
    cmd.entry_index = item.entry_index;
    if (item.mode) begin
      // reads go to any channel, out of range answers zero
      cmd.kind = chav_pkg::in_range(item.level, item.entry_index) ?
                 chav_pkg::CMD_READ : chav_pkg::CMD_ZERO;
      push     = accept;
    end else begin
      // records on inactive channels are dropped here
      cmd.kind = chav_pkg::CMD_RECORD;
      push     = accept && ({1'b0, item.channel} < active_channels);
    end
  end

endmodule

[rtl/core/chav_queue.sv]
// two entry command queue between front and back
module chav_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  chav_pkg::cmd_t  din,
  input  logic            pop,
  output chav_pkg::cmd_t  dout,
  output logic            full,
  output logic            empty
);

  chav_pkg::cmd_t ent [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = ent[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

[rtl/core/chav_back.sv]
// back end: history stores, cascade sequencer, divider and result register
module chav_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  chav_pkg::cmd_t     hd,
  output logic               pop,
  output logic               result_valid,
  output chav_pkg::result_t  result,
  input  logic               result_stall
);

  localparam int POS_W = chav_pkg::POS_W;
  localparam int SA_W  = $clog2(chav_pkg::CHANNELS * chav_pkg::SECOND_DEPTH);
  localparam int MA_W  = $clog2(chav_pkg::CHANNELS * chav_pkg::MINUTE_DEPTH);
  localparam int HA_W  = $clog2(chav_pkg::CHANNELS * chav_pkg::HOUR_DEPTH);
  localparam int DA_W  = $clog2(chav_pkg::CHANNELS * chav_pkg::DAY_DEPTH);
  localparam int YA_W  = $clog2(chav_pkg::CHANNELS * chav_pkg::YEAR_DEPTH);

  // reciprocal of each averaged depth, rounded up, with its shift
  localparam int SEC_SH = 32 + $clog2(chav_pkg::SECOND_DEPTH);
  localparam int MIN_SH = 32 + $clog2(chav_pkg::MINUTE_DEPTH);
  localparam int HR_SH  = 32 + $clog2(chav_pkg::HOUR_DEPTH);
  localparam int DAY_SH = 32 + $clog2(chav_pkg::DAY_DEPTH);
  localparam logic [63:0] SEC_RCP = ((64'd1 << SEC_SH) + 64'(chav_pkg::SECOND_DEPTH) - 64'd1)
                                    / 64'(chav_pkg::SECOND_DEPTH);
  localparam logic [63:0] MIN_RCP = ((64'd1 << MIN_SH) + 64'(chav_pkg::MINUTE_DEPTH) - 64'd1)
                                    / 64'(chav_pkg::MINUTE_DEPTH);
  localparam logic [63:0] HR_RCP  = ((64'd1 << HR_SH) + 64'(chav_pkg::HOUR_DEPTH) - 64'd1)
                                    / 64'(chav_pkg::HOUR_DEPTH);
  localparam logic [63:0] DAY_RCP = ((64'd1 << DAY_SH) + 64'(chav_pkg::DAY_DEPTH) - 64'd1)
                                    / 64'(chav_pkg::DAY_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WRITE  = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_RDEMIT = 3'd5;
  localparam logic [2:0] S_SHIFT  = 3'd6;

  logic [2:0]       state;
  logic [2:0]       lvl;
  logic [1:0]       ch;
  logic [31:0]      work;
  logic [POS_W-1:0] cnt;
  logic [64:0]      prod;
  logic             zero_rd;

  logic [POS_W-1:0] phase [chav_pkg::LEVELS][chav_pkg::CHANNELS];
  logic             full  [chav_pkg::LEVELS][chav_pkg::CHANNELS];

  logic [31:0] smem [chav_pkg::CHANNELS * chav_pkg::SECOND_DEPTH];
  logic [31:0] mmem [chav_pkg::CHANNELS * chav_pkg::MINUTE_DEPTH];
  logic [31:0] hmem [chav_pkg::CHANNELS * chav_pkg::HOUR_DEPTH];
  logic [31:0] dmem [chav_pkg::CHANNELS * chav_pkg::DAY_DEPTH];
  logic [31:0] ymem [chav_pkg::CHANNELS * chav_pkg::YEAR_DEPTH];
  logic [31:0] s_rd, m_rd, h_rd, d_rd, y_rd;
  logic [31:0] rdata;

  logic             we;
  logic [POS_W-1:0] wpos;
  logic             re;
  logic [POS_W-1:0] rpos;
  logic [1:0]       rch;

  logic [POS_W-1:0] dcur;
  logic [POS_W-1:0] pcur;
  logic [POS_W-1:0] p1;
  logic             wrap;
  logic [2:0]       nlvl;
  logic             last_avg;

  logic [POS_W-1:0] hpos;
  logic [POS_W-1:0] hphase;
  logic             hfull;
  logic [POS_W-1:0] hdep;
  logic [POS_W:0]   hsum;
  logic [POS_W-1:0] hphys;
  logic             unwritten;

  logic [32:0]      rmul;
  logic [5:0]       rsh;

  logic               slot_free;
  logic               load;
  chav_pkg::result_t  out_next;

  // per level depth, write pointer and cascade flags of the current channel
  assign dcur = chav_pkg::depth_of(lvl);
  assign pcur = phase[lvl][ch];
  assign p1   = pcur + POS_W'(1);
  assign wrap = (p1 == dcur);
  assign nlvl = lvl + 3'd1;
  assign last_avg = (lvl == chav_pkg::LVL_DAY) ||
                    (phase[nlvl][ch] != chav_pkg::depth_of(nlvl) - POS_W'(1));

  // read lookup for the command at the head of the queue
  assign hpos      = POS_W'(hd.entry_index);
  assign hphase    = phase[hd.level][hd.channel];
  assign hfull     = full[hd.level][hd.channel];
  assign hdep      = chav_pkg::depth_of(hd.level);
  assign hsum      = {1'b0, hphase} + {1'b0, hpos};
  assign hphys     = hfull ? ((hsum >= {1'b0, hdep}) ? POS_W'(hsum - {1'b0, hdep})
                                                     : POS_W'(hsum))
                           : hpos;
  assign unwritten = !hfull && (hpos >= hphase);

  assign slot_free = !result_valid || !result_stall;

  always_comb begin
    case (lvl)
      chav_pkg::LVL_SECOND: rdata = s_rd;
      chav_pkg::LVL_MINUTE: rdata = m_rd;
      chav_pkg::LVL_HOUR:   rdata = h_rd;
      chav_pkg::LVL_DAY:    rdata = d_rd;
      chav_pkg::LVL_YEAR:   rdata = y_rd;
      default:              rdata = '0;
    endcase
  end

  // reciprocal of the level being averaged
  always_comb begin
    case (lvl)
      chav_pkg::LVL_SECOND: begin
        rmul = 33'(SEC_RCP);
        rsh  = 6'(SEC_SH);
      end
      chav_pkg::LVL_MINUTE: begin
        rmul = 33'(MIN_RCP);
        rsh  = 6'(MIN_SH);
      end
      chav_pkg::LVL_HOUR: begin
        rmul = 33'(HR_RCP);
        rsh  = 6'(HR_SH);
      end
      chav_pkg::LVL_DAY: begin
        rmul = 33'(DAY_RCP);
        rsh  = 6'(DAY_SH);
      end
      default: begin
        rmul = '0;
        rsh  = '0;
      end
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    we       = 1'b0;
    wpos     = pcur;
    re       = 1'b0;
    rpos     = cnt;
    rch      = ch;
    load     = 1'b0;
    out_next = '0;
    unique case (state)
      S_IDLE: begin
        pop  = !q_empty;
        rpos = hphys;
        rch  = hd.channel;
        re   = !q_empty && (hd.kind == chav_pkg::CMD_READ) && !unwritten;
      end
      S_WRITE: begin
        we = 1'b1;
      end
      S_SUM: begin
        re = (cnt < dcur);
      end
      S_EMIT: begin
        load = slot_free;
        out_next = '{value: work, out_level: nlvl, out_channel: ch,
                     is_readback: 1'b0, last: last_avg};
      end
      S_RDEMIT: begin
        load = slot_free;
        out_next = '{value: zero_rd ? 32'd0 : rdata, out_level: lvl, out_channel: ch,
                     is_readback: 1'b1, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // stores: written at the write pointer, read registered
  always_ff @(posedge clk) begin
    if (we && lvl == chav_pkg::LVL_SECOND) begin
      smem[SA_W'(ch * chav_pkg::SECOND_DEPTH + wpos)] <= work;
    end
    if (re) begin
      s_rd <= smem[SA_W'(rch * chav_pkg::SECOND_DEPTH + rpos)];
    end
  end

  always_ff @(posedge clk) begin
    if (we && lvl == chav_pkg::LVL_MINUTE) begin
      mmem[MA_W'(ch * chav_pkg::MINUTE_DEPTH + wpos)] <= work;
    end
    if (re) begin
      m_rd <= mmem[MA_W'(rch * chav_pkg::MINUTE_DEPTH + rpos)];
    end
  end

  always_ff @(posedge clk) begin
    if (we && lvl == chav_pkg::LVL_HOUR) begin
      hmem[HA_W'(ch * chav_pkg::HOUR_DEPTH + wpos)] <= work;
    end
    if (re) begin
      h_rd <= hmem[HA_W'(rch * chav_pkg::HOUR_DEPTH + rpos)];
    end
  end

  always_ff @(posedge clk) begin
    if (we && lvl == chav_pkg::LVL_DAY) begin
      dmem[DA_W'(ch * chav_pkg::DAY_DEPTH + wpos)] <= work;
    end
    if (re) begin
      d_rd <= dmem[DA_W'(rch * chav_pkg::DAY_DEPTH + rpos)];
    end
  end

  always_ff @(posedge clk) begin
    if (we && lvl == chav_pkg::LVL_YEAR) begin
      ymem[YA_W'(ch * chav_pkg::YEAR_DEPTH + wpos)] <= work;
    end
    if (re) begin
      y_rd <= ymem[YA_W'(rch * chav_pkg::YEAR_DEPTH + rpos)];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= '0;
      ch    <= '0;
      for (int l = 0; l < chav_pkg::LEVELS; l++) begin
        for (int c = 0; c < chav_pkg::CHANNELS; c++) begin
          phase[l][c] <= '0;
          full[l][c]  <= 1'b0;
        end
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ch <= hd.channel;
            unique case (hd.kind)
              chav_pkg::CMD_RECORD: begin
                lvl   <= chav_pkg::LVL_SECOND;
                work  <= hd.sample;
                state <= S_WRITE;
              end
              chav_pkg::CMD_READ: begin
                lvl     <= hd.level;
                zero_rd <= unwritten;
                state   <= S_RDEMIT;
              end
              default: begin
                lvl     <= hd.level;
                zero_rd <= 1'b1;
                state   <= S_RDEMIT;
              end
            endcase
          end
        end
        S_WRITE: begin
          if (wrap) begin
            phase[lvl][ch] <= '0;
            full[lvl][ch]  <= 1'b1;
          end else begin
            phase[lvl][ch] <= p1;
          end
          if (wrap && lvl != chav_pkg::LVL_YEAR) begin
            cnt   <= '0;
            work  <= '0;
            state <= S_SUM;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUM: begin
          if (cnt != '0) begin
            work <= work + rdata;
          end
          if (cnt == dcur) begin
            state <= S_DIV;
          end
          cnt <= cnt + POS_W'(1);
        end
        S_DIV: begin
          // sum times the rounded up reciprocal, exact for any 32-bit sum
          prod  <= 65'(work) * 65'(rmul);
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          work  <= 32'(prod >> rsh);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            lvl   <= nlvl;
            state <= S_WRITE;
          end
        end
        S_RDEMIT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= out_next;
    end
  end

  a_sum_level: assert property (@(posedge clk) disable iff (rst)
    state == S_SUM |-> lvl < chav_pkg::LVL_YEAR)
    else $error("summing a level that does not cascade");

  a_write_ptr: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> pcur < dcur)
    else $error("write pointer beyond level depth");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> state == S_SHIFT)
    else $error("divider left early");

  a_avg_level: assert property (@(posedge clk) disable iff (rst)
    load && !out_next.is_readback |-> out_next.out_level != chav_pkg::LVL_SECOND)
    else $error("average tagged with second level");

endmodule

[rtl/core/cascaded_history_averager.sv]
// top level of the cascaded history averager
// Keeps per channel a round robin history of seconds, minute, hour, day and
// year averages and returns any stored entry on request. A record transfer
// that causes no cascade passes through the write state and back to idle in
// the back end. Each cascade step sums the filled level one entry per cycle
// from its store memory, then a reciprocal multiply and a shift divide the
// sum, and the average is emitted and written into the next level. Each store
// has a single read port, shared by readbacks and cascade sums. A read transfer
// fetches its entry into a store output register as it leaves the queue and
// loads the result register once the output slot is free. Items are processed
// one at a time in the back end; the front end keeps accepting into a two entry
// queue. Stores start empty: the write pointer and fill flag of each level
// mark unwritten entries, which read as zero, so no clearing pass is needed.
module cascaded_history_averager (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_data,
  input  logic               item_valid,
  input  chav_pkg::item_t    item,
  output logic               item_stall,
  output logic               result_valid,
  output chav_pkg::result_t  result,
  input  logic               result_stall
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  chav_pkg::cmd_t q_in;
  chav_pkg::cmd_t q_out;

  // accept and classify
  chav_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .q_full     (q_full),
    .push       (q_push),
    .cmd        (q_in)
  );

  // decouples the two sides
  chav_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .pop   (q_pop),
    .dout  (q_out),
    .full  (q_full),
    .empty (q_empty)
  );

  // stores, cascade and result transfer
  chav_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .hd           (q_out),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

endmodule

[bench/tb.sv]
// self-checking testbench of the cascaded history averager
module tb;

  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;
  localparam int   NUM_LEVELS  = 5;
  localparam int   ROW_MAX     = chav_pkg::DAY_DEPTH;
  localparam int   CYCLE_LIMIT = 2000000;
  localparam int   SETTLE      = 50;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;
  logic    item_valid = 1'b0;
  chav_pkg::item_t   item = '0;
  logic    item_stall;
  logic    result_valid;
  chav_pkg::result_t result;
  logic    result_stall = 1'b0;

  cascaded_history_averager dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .item_valid(item_valid), .item(item), .item_stall(item_stall),
    .result_valid(result_valid), .result(result), .result_stall(result_stall)
  );

  // model of the history stores, level by level
  logic [31:0] history [NUM_LEVELS][chav_pkg::CHANNELS][ROW_MAX];
  int          write_pos [NUM_LEVELS][chav_pkg::CHANNELS];
  bit          level_full [NUM_LEVELS][chav_pkg::CHANNELS];
  int          years_held [chav_pkg::CHANNELS];
  logic [2:0]  active_count;

  chav_pkg::item_t   pending_items[$];
  chav_pkg::result_t expected_results[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  bit      hold_req = 0;

  function automatic int level_depth(int lvl);
    case (lvl)
      chav_pkg::LVL_SECOND: return chav_pkg::SECOND_DEPTH;
      chav_pkg::LVL_MINUTE: return chav_pkg::MINUTE_DEPTH;
      chav_pkg::LVL_HOUR:   return chav_pkg::HOUR_DEPTH;
      chav_pkg::LVL_DAY:    return chav_pkg::DAY_DEPTH;
      chav_pkg::LVL_YEAR:   return chav_pkg::YEAR_DEPTH;
      default:    return 0;
    endcase
  endfunction

  // write v into a level row; returns 1 when the row wraps and cascades
  function automatic bit push_entry(int lvl, int ch, logic [31:0] v);
    int d;
    d = level_depth(lvl);
    if (level_full[lvl][ch]) begin
      for (int m = 0; m < d - 1; m++) history[lvl][ch][m] = history[lvl][ch][m+1];
      history[lvl][ch][d-1] = v;
    end else begin
      history[lvl][ch][write_pos[lvl][ch]] = v;
    end
    write_pos[lvl][ch]++;
    if (write_pos[lvl][ch] >= d) begin
      write_pos[lvl][ch] = 0;
      level_full[lvl][ch] = 1;
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [31:0] row_average(int lvl, int ch);
    logic [31:0] sum;
    sum = '0;
    for (int m = 0; m < level_depth(lvl); m++) sum += history[lvl][ch][m];
    return sum / level_depth(lvl);
  endfunction

  // work out the results that one accepted transfer causes
  task automatic predict_history(chav_pkg::item_t it);
    chav_pkg::result_t r;
    logic [31:0] avg;
    int ch;
    int lvl;
    int n;
    ch = it.channel;
    r = '0;
    if (it.mode == MODE_READ) begin
      r.value = '0;
      if (it.level <= chav_pkg::LVL_YEAR && int'(it.entry_index) < level_depth(it.level))
        r.value = history[it.level][ch][it.entry_index];
      r.out_level = it.level;
      r.out_channel = it.channel;
      r.is_readback = 1'b1;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    // inactive channel: nothing changes
    if (ch >= active_count) return;
    n = 0;
    avg = it.sample;
    lvl = chav_pkg::LVL_SECOND;
    // seconds through days cascade into the next level up
    while (lvl < chav_pkg::LVL_YEAR && push_entry(lvl, ch, avg)) begin
      avg = row_average(lvl, ch);
      lvl++;
      r.value = avg;
      r.out_level = 3'(lvl);
      r.out_channel = it.channel;
      r.is_readback = 1'b0;
      r.last = 1'b0;
      expected_results.push_back(r);
      n++;
    end
    // a new year average goes in the year row, dropping the oldest when full
    if (lvl == chav_pkg::LVL_YEAR) begin
      if (years_held[ch] >= chav_pkg::YEAR_DEPTH) begin
        for (int m = 0; m < chav_pkg::YEAR_DEPTH - 1; m++)
          history[chav_pkg::LVL_YEAR][ch][m] = history[chav_pkg::LVL_YEAR][ch][m+1];
        history[chav_pkg::LVL_YEAR][ch][chav_pkg::YEAR_DEPTH-1] = avg;
      end else begin
        history[chav_pkg::LVL_YEAR][ch][years_held[ch]] = avg;
        years_held[ch]++;
      end
    end
    if (n > 0) expected_results[$].last = 1'b1;
  endtask

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    fail_count++;
  endtask

  function automatic chav_pkg::item_t make_record(int ch, logic [31:0] s);
    chav_pkg::item_t it;
    it = '0;
    it.mode = MODE_RECORD;
    it.channel = 2'(ch);
    it.sample = s;
    it.level = 3'($urandom_range(0, 7));
    it.entry_index = 9'($urandom_range(0, 511));
    return it;
  endfunction

  function automatic chav_pkg::item_t make_read(int ch, int lvl, int idx);
    chav_pkg::item_t it;
    it.mode = MODE_READ;
    it.channel = 2'(ch);
    it.sample = $urandom;
    it.level = 3'(lvl);
    it.entry_index = 9'(idx);
    return it;
  endfunction

  // mostly records on live channels, some reads, some noise
  function automatic chav_pkg::item_t make_random_item();
    int pick;
    int lvl;
    pick = $urandom_range(0, 99);
    if (pick < 80 && active_count > 0)
      return make_record($urandom_range(0, active_count - 1), $urandom);
    if (pick < 88)
      return make_record($urandom_range(0, 3), $urandom);
    lvl = $urandom_range(0, 9) < 8 ? $urandom_range(0, 4) : $urandom_range(5, 7);
    if ($urandom_range(0, 3) == 0)
      return make_read($urandom_range(0, 3), lvl, $urandom_range(0, 511));
    return make_read($urandom_range(0, 3), lvl,
                     $urandom_range(0, level_depth(lvl) > 0 ? level_depth(lvl) - 1 : 0));
  endfunction

  // clock and cycle limit
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      // an accepted transfer updates the model right away
      if (item_valid && !item_stall) predict_history(item);
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern changes every window, plus one long hold
  int stall_mode = 0;
  int window_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
      end
      if (window_left == 0) begin
        window_left = $urandom_range(10, 80);
        stall_mode = $urandom_range(0, 3);
      end else begin
        window_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= ~result_stall;
        endcase
      end
    end
  end

  // monitor: every result transfer against the oldest expectation
  chav_pkg::result_t want;
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 32'd0, result.value);
      end else begin
        want = expected_results.pop_front();
        if (result.value !== want.value) report_mismatch("value", want.value, result.value);
        if (result.out_level !== want.out_level)
          report_mismatch("out_level", want.out_level, result.out_level);
        if (result.out_channel !== want.out_channel)
          report_mismatch("out_channel", want.out_channel, result.out_channel);
        if (result.is_readback !== want.is_readback)
          report_mismatch("is_readback", want.is_readback, result.is_readback);
        if (result.last !== want.last) report_mismatch("last", want.last, result.last);
      end
    end
  end

  // wait until the block has answered everything, then let it settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_active(logic [2:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    active_count = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  int lvl_pick;
  logic [2:0] phase_counts [6] = '{3'd4, 3'd1, 3'd0, 3'd2, 3'd3, 3'd4};
  initial begin
    for (int l = 0; l < NUM_LEVELS; l++)
      for (int c = 0; c < chav_pkg::CHANNELS; c++) begin
        write_pos[l][c] = 0;
        level_full[l][c] = 0;
        for (int m = 0; m < ROW_MAX; m++) history[l][c][m] = '0;
      end
    for (int c = 0; c < chav_pkg::CHANNELS; c++) years_held[c] = 0;
    active_count = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: no channel is live after reset, so records are ignored
    pending_items.push_back(make_record(0, 32'hFFFF_FFFF));
    pending_items.push_back(make_record(3, 32'h0));
    // reads before anything was written, at each level's edges
    for (int l = 0; l < NUM_LEVELS; l++) begin
      pending_items.push_back(make_read(l % 4, l, 0));
      pending_items.push_back(make_read(3 - l % 4, l, level_depth(l) - 1));
      pending_items.push_back(make_read(l % 4, l, level_depth(l)));
    end
    // levels past the year level and the largest index
    pending_items.push_back(make_read(1, 5, 0));
    pending_items.push_back(make_read(2, 7, 511));
    pending_items.push_back(make_read(0, 0, 511));
    wait_drained();

    // directed: extreme samples on live channels, read back
    write_active(3'd4);
    pending_items.push_back(make_record(0, 32'hFFFF_FFFF));
    pending_items.push_back(make_record(3, 32'h0));
    pending_items.push_back(make_record(3, 32'hFFFF_FFFF));
    pending_items.push_back(make_read(0, chav_pkg::LVL_SECOND, 0));
    pending_items.push_back(make_read(3, chav_pkg::LVL_SECOND, 1));
    wait_drained();

    // random phases over several channel counts
    for (int p = 0; p < 6; p++) begin
      write_active(phase_counts[p]);
      if (p == 1) hold_req = 1;
      for (int k = 0; k < (p == 1 ? 130 : 35); k++) pending_items.push_back(make_random_item());
      // reads of in-range entries of the second and minute levels
      for (int k = 0; k < 4; k++) begin
        lvl_pick = $urandom_range(0, 1);
        pending_items.push_back(make_read($urandom_range(0, 3), lvl_pick,
                                          $urandom_range(0, level_depth(lvl_pick) - 1)));
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[cascaded_history_averager.f]
rtl/core/chav_pkg.sv
rtl/core/chav_front.sv
rtl/core/chav_queue.sv
rtl/core/chav_back.sv
rtl/core/cascaded_history_averager.sv
bench/tb.sv
